FILE: design/sha512_pkg.sv
// sha512 package: shared types, codes and constants of the stream hasher
// used by the controller, datapath and top level; depends on nothing
`default_nettype none
package sha512_pkg;

  typedef logic [63:0] word_t;

  localparam int BCNT_W = 125;  // message length in bytes; bit length is this times 8
  localparam int ROUNDS = 80;

  // block kinds: how the 16 schedule words of a block are sourced
  localparam logic [1:0] KIND_DATA = 2'd0;  // all words from the block buffer
  localparam logic [1:0] KIND_ONE  = 2'd1;  // buffer, pad word, zeros, length
  localparam logic [1:0] KIND_PADA = 2'd2;  // buffer, pad word, zeros
  localparam logic [1:0] KIND_PADB = 2'd3;  // zeros and length

  typedef struct packed {
    logic       absorb;
    logic       load;
    logic       round_en;
    logic       update;
    logic       reinit;
    logic       err;
    logic [1:0] kind;
    logic [6:0] round;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic blk_done;  // the absorbed byte completes a block
    logic ovf;
    logic two_blk;   // padding needs a second block
  } st_t;

  localparam word_t INIT_HASH [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

  localparam word_t ROUND_K [ROUNDS] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

endpackage
`default_nettype wire

FILE: design/sha512_if.sv
// sha512 channel interfaces: byte input channel and digest output channel
// valid/ready handshake; depends on nothing
`default_nettype none
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  logic        too_long;
  modport source (output valid, output digest_word, output word_index, output last,
                  output too_long, input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                input too_long, output ready);
endinterface
`default_nettype wire

FILE: design/sha512_ram.sv
// sha512 generic ram: one write port, one read port with registered data
// depends on nothing
`default_nettype none
module sha512_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/sha512_ctrl.sv
// sha512 controller: sequences absorb, compression rounds and digest output
// depends on sha512_pkg
`default_nettype none
module sha512_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_mode,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire sha512_pkg::st_t st,
  output sha512_pkg::cmd_t     cmd
);
  import sha512_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;
  localparam logic [2:0] S_ERR    = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] kind, kind_next;
  logic [6:0] round, round_next;
  logic [2:0] idx, idx_next;

  // next state and commands
  always_comb begin
    state_next = state;
    kind_next  = kind;
    round_next = round;
    idx_next   = idx;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.kind   = kind;
    cmd.round  = round;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_mode) begin
            cmd.absorb = 1'b1;
            if (st.blk_done) begin
              kind_next  = KIND_DATA;
              state_next = S_LOAD;
            end
          end else if (st.ovf) begin
            state_next = S_ERR;
          end else begin
            kind_next  = st.two_blk ? KIND_PADA : KIND_ONE;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        round_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_next   = round + 7'd1;
        if (round == 7'(ROUNDS - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        idx_next   = '0;
        if (kind == KIND_PADA) begin
          kind_next  = KIND_PADB;
          state_next = S_LOAD;
        end else if (kind == KIND_DATA) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        cmd.err   = 1'b1;
        if (out_ready) begin
          cmd.reinit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= KIND_DATA;
      round <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      round <= round_next;
      idx   <= idx_next;
    end
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> round < 7'(ROUNDS))
    else $error("round counter out of range");
  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 7'(ROUNDS - 1)) |=> state == S_UPDATE)
    else $error("compression did not end after the last round");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_second_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && kind == KIND_PADA) |=> (state == S_LOAD && kind == KIND_PADB))
    else $error("second padding block skipped");
`endif
endmodule
`default_nettype wire

FILE: design/sha512_dp.sv
// sha512 datapath: block buffer, length counter, message schedule and round logic
// depends on sha512_pkg and sha512_ram
`default_nettype none
module sha512_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       data_byte,
  input  wire sha512_pkg::cmd_t cmd,
  output sha512_pkg::st_t       st,
  output logic [63:0]           digest_word,
  output logic [2:0]            word_index,
  output logic                  last,
  output logic                  too_long
);
  import sha512_pkg::*;

  word_t             hash [8];
  word_t             wv [8];
  word_t             win [16];
  word_t             acc;
  logic [6:0]        fill;
  logic [BCNT_W-1:0] bcnt;
  logic              ovf;

  word_t             acc_ins, pad_word, src, w, rdata, s0, s1, t1, t2;
  logic [BCNT_W:0]   bcnt_inc;
  logic [3:0]        raddr, widx;
  logic [2:0]        k;

  assign k        = fill[2:0];
  assign bcnt_inc = {1'b0, bcnt} + 1'b1;

  // status to the controller
  assign st.ovf      = ovf;
  assign st.blk_done = !ovf && (fill == 7'd127) && !bcnt_inc[BCNT_W];
  assign st.two_blk  = fill >= 7'd112;

  // byte insert into the word being collected, and the padded partial word
  always_comb begin
    acc_ins = acc;
    acc_ins[63 - 8*k -: 8] = data_byte;
    for (int p = 0; p < 8; p++) begin
      if (p < k) begin
        pad_word[63 - 8*p -: 8] = acc[63 - 8*p -: 8];
      end else if (p == k) begin
        pad_word[63 - 8*p -: 8] = 8'h80;
      end else begin
        pad_word[63 - 8*p -: 8] = 8'h00;
      end
    end
  end

  assign raddr = cmd.load ? 4'd0 : cmd.round[3:0] + 4'd1;

  sha512_ram #(.WIDTH(64), .DEPTH(16)) u_buf (
    .clk   (clk),
    .we    (cmd.absorb && !ovf && k == 3'd7),
    .waddr (fill[6:3]),
    .wdata (acc_ins),
    .raddr (raddr),
    .rdata (rdata)
  );

  // schedule word source of the first sixteen rounds
  assign widx = cmd.round[3:0];
  always_comb begin
    src = rdata;
    if (cmd.kind != KIND_DATA) begin
      if (cmd.kind == KIND_PADB || widx > fill[6:3]) begin
        src = '0;
      end else if (widx == fill[6:3]) begin
        src = pad_word;
      end
      if (cmd.kind != KIND_PADA) begin
        if (widx == 4'd14) begin
          src = bcnt[BCNT_W-1 -: 64];
        end else if (widx == 4'd15) begin
          src = {bcnt[BCNT_W-65:0], 3'b000};
        end
      end
    end
  end

  // message expansion and round function
  always_comb begin
    s0 = {win[1][0], win[1][63:1]} ^ {win[1][7:0], win[1][63:8]} ^ (win[1] >> 7);
    s1 = {win[14][18:0], win[14][63:19]} ^ {win[14][60:0], win[14][63:61]}
         ^ (win[14] >> 6);
    w  = (cmd.round < 7'd16) ? src : win[0] + s0 + win[9] + s1;
    t1 = wv[7]
       + ({wv[4][13:0], wv[4][63:14]} ^ {wv[4][17:0], wv[4][63:18]}
          ^ {wv[4][40:0], wv[4][63:41]})
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + ROUND_K[cmd.round] + w;
    t2 = ({wv[0][27:0], wv[0][63:28]} ^ {wv[0][33:0], wv[0][63:34]}
          ^ {wv[0][38:0], wv[0][63:39]})
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // working variables, schedule window and byte accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wv <= hash;
    end else if (cmd.round_en) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w;
    end
    if (cmd.absorb && !ovf) begin
      acc <= acc_ins;
    end
  end

  // chaining state, fill index, length counter and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      hash <= INIT_HASH;
      fill <= '0;
      bcnt <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + wv[i];
        end
      end
      if (cmd.absorb && !ovf) begin
        fill <= fill + 7'd1;
        bcnt <= bcnt_inc[BCNT_W-1:0];
        if (bcnt_inc[BCNT_W]) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  // result payload
  assign digest_word = cmd.err ? 64'd0 : hash[cmd.idx];
  assign word_index  = cmd.err ? 3'd0 : cmd.idx;
  assign last        = cmd.err || cmd.idx == 3'd7;
  assign too_long    = cmd.err;
endmodule
`default_nettype wire

FILE: design/sha512_stream_hasher_core.sv
// sha512 stream hasher top level: one message byte per transaction, SHA-512 digest out
// bytes are taken only while idle; a byte that fills a block runs load, the rounds, update
// finish compresses one padded block, or two if padding spills over, then sends eight
// results, one per cycle while the sink is ready, or one too_long result on overflow
// rst (synchronous) restores the initial hash, empties the buffer and clears the length
// depends on sha512_pkg, sha512_if, sha512_ctrl and sha512_dp
`default_nettype none
module sha512_stream_hasher_core (
  input  wire logic    clk,
  input  wire logic    rst,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);
  import sha512_pkg::*;

  cmd_t cmd;
  st_t  st;

  sha512_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  sha512_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .st          (st),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last        (out_ch.last),
    .too_long    (out_ch.too_long)
  );
endmodule
`default_nettype wire
